// File: hw/rtl/snv_pkg.sv
// Package for the SPARQL/Turtle name validator: name kinds, verdict codes,
// name state type and the character class functions. No dependencies.
package snv_pkg;

    localparam int unsigned CpW = 21;

    typedef logic [CpW-1:0] codepoint_t;

    typedef enum logic [1:0] {
        KIND_VARIABLE = 2'd0,
        KIND_PREFIXED = 2'd1,
        KIND_LOCAL    = 2'd2,
        KIND_BNODE    = 2'd3
    } name_kind_t;

    typedef enum logic [1:0] {
        VERDICT_INVALID = 2'd0,
        VERDICT_VALID   = 2'd1,
        VERDICT_EMPTY   = 2'd2
    } verdict_t;

    typedef struct packed {
        logic allow_first;
        logic allow_minus;
        logic allow_esc;
    } kind_flags_t;

    typedef struct packed {
        codepoint_t partial;
        logic [1:0] cont_left;
        logic       seen_first;
        logic       esc_pending;
        logic [1:0] hex_left;
        logic       prev_dot;
        logic       failed;
    } name_state_t;

    localparam logic [7:0] ChPercent   = 8'h25;
    localparam logic [7:0] ChColon     = 8'h3A;
    localparam logic [7:0] ChDot       = 8'h2E;
    localparam logic [7:0] ChMinus     = 8'h2D;
    localparam logic [7:0] ChUnder     = 8'h5F;
    localparam logic [7:0] ChZero      = 8'h30;
    localparam logic [7:0] ChNine      = 8'h39;
    localparam logic [7:0] ChBackslash = 8'h5C;

    localparam codepoint_t CpMax = 21'h10FFFF;

    function automatic kind_flags_t kind_flags(input name_kind_t kind);
        kind_flags_t f;
        f.allow_first = (kind != KIND_PREFIXED);
        f.allow_minus = (kind != KIND_VARIABLE);
        f.allow_esc   = (kind == KIND_LOCAL);
        return f;
    endfunction

    function automatic logic in_rng(input codepoint_t c, input codepoint_t lo,
                                    input codepoint_t hi);
        return (c >= lo) && (c <= hi);
    endfunction

    function automatic logic is_digit(input codepoint_t c);
        return in_rng(c, {13'd0, ChZero}, {13'd0, ChNine});
    endfunction

    function automatic logic is_start_char(input codepoint_t c);
        return (c == {13'd0, ChColon}) || in_rng(c, 21'h41, 21'h5A) ||
               (c == {13'd0, ChUnder}) || in_rng(c, 21'h61, 21'h7A) ||
               in_rng(c, 21'hC0, 21'hD6) || in_rng(c, 21'hD8, 21'hF6) ||
               in_rng(c, 21'hF8, 21'h2FF) || in_rng(c, 21'h370, 21'h37D) ||
               in_rng(c, 21'h37F, 21'h1FFF) || in_rng(c, 21'h200C, 21'h200D) ||
               in_rng(c, 21'h2070, 21'h218F) || in_rng(c, 21'h2C00, 21'h2FEF) ||
               in_rng(c, 21'h3001, 21'hD7FF) || in_rng(c, 21'hF900, 21'hFDCF) ||
               in_rng(c, 21'hFDF0, 21'hFFFD) || in_rng(c, 21'h10000, 21'hEFFFF);
    endfunction

    function automatic logic is_name_char(input codepoint_t c);
        return is_start_char(c) || (c == {13'd0, ChMinus}) ||
               (c == {13'd0, ChDot}) || is_digit(c) || (c == 21'hB7) ||
               in_rng(c, 21'h300, 21'h36F) || in_rng(c, 21'h203F, 21'h2040);
    endfunction

    function automatic logic is_hex(input codepoint_t c);
        return is_digit(c) || in_rng(c, 21'h61, 21'h66) || in_rng(c, 21'h41, 21'h46);
    endfunction

    function automatic logic is_escapable(input codepoint_t c);
        logic r;
        r = 1'b0;
        if (c[CpW-1:8] == '0) begin
            case (c[7:0])
                8'h5F, 8'h7E, 8'h2E, 8'h2D, 8'h21, 8'h24, 8'h26, 8'h27,
                8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h3B, 8'h3D, 8'h2F,
                8'h3F, 8'h23, 8'h40, 8'h25: r = 1'b1;
                default: r = 1'b0;
            endcase
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/sparql_name_validator.sv
// Top level of the SPARQL/Turtle name validator: UTF-8 decode, character
// class checks and verdict per name. Depends on snv_pkg.

// The block takes a name one byte per item and accepts one item every cycle
// unless held as below. An item passes an input register and is then decoded
// and judged against the running name state; for the item marked tlast the
// verdict is loaded into the output register at the same edge that stores the
// name state. The output register lets the input side keep moving while a
// verdict waits; only a tlast item that meets a full, stalled output register
// holds the input. The user must write name_kind through the cfg channel
// between names; the block itself does not enforce this.
module sparql_name_validator
    import snv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] name_byte
    input  logic [0:0] s_tuser,   // [0] byte_present
    input  logic       s_tlast,   // last_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [1:0] verdict, [7:2] zero
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_data   // name_kind
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_present_reg;
    logic        in_last_reg;
    name_kind_t  kind_reg;
    name_state_t st_reg;
    name_state_t st_next;
    logic        out_valid_reg;
    verdict_t    out_verdict_reg;
    verdict_t    verdict_next;
    logic        advance;

    kind_flags_t flags;
    logic        char_valid;
    codepoint_t  char_cp;
    codepoint_t  shifted;
    logic        judge_ok;
    logic        esc_after;
    logic [1:0]  hex_after;
    name_state_t post;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {6'd0, out_verdict_reg};
    assign flags     = kind_flags(kind_reg);
    assign shifted   = {st_reg.partial[CpW-7:0], in_byte_reg[5:0]};
    // code point completed by this byte: the byte itself, or the decoded sequence
    assign char_cp   = (st_reg.cont_left != 2'd0) ? shifted : {13'd0, in_byte_reg};

    // character judgment for a fully decoded code point
    always_comb
    begin
        judge_ok  = 1'b0;
        esc_after = st_reg.esc_pending;
        hex_after = st_reg.hex_left;
        if (st_reg.hex_left != 2'd0)
        begin
            judge_ok  = is_hex(char_cp);
            hex_after = st_reg.hex_left - 2'd1;
        end
        else if (st_reg.esc_pending)
        begin
            esc_after = 1'b0;
            judge_ok  = flags.allow_esc && is_escapable(char_cp);
        end
        else if (char_cp == {13'd0, ChBackslash})
        begin
            esc_after = 1'b1;
            judge_ok  = 1'b1;
        end
        else if (char_cp == {13'd0, ChColon})
        begin
            judge_ok = flags.allow_esc;
        end
        else if (char_cp == {13'd0, ChPercent})
        begin
            judge_ok  = flags.allow_esc;
            hex_after = 2'd2;
        end
        else if (!st_reg.seen_first)
        begin
            if (is_digit(char_cp) || char_cp == {13'd0, ChUnder})
                judge_ok = flags.allow_first;
            else
                judge_ok = is_start_char(char_cp);
        end
        else
        begin
            if (char_cp == {13'd0, ChMinus})
                judge_ok = flags.allow_minus;
            else
                judge_ok = is_name_char(char_cp);
        end
    end

    // UTF-8 decode, state update and next verdict
    always_comb
    begin
        post       = st_reg;
        char_valid = 1'b0;
        if (in_present_reg && !st_reg.failed)
        begin
            if (st_reg.cont_left == 2'd0)
            begin
                if (in_byte_reg < 8'h80)
                    char_valid = 1'b1;
                else if (in_byte_reg >= 8'hC2 && in_byte_reg <= 8'hDF)
                begin
                    post.partial   = {16'd0, in_byte_reg[4:0]};
                    post.cont_left = 2'd1;
                end
                else if (in_byte_reg >= 8'hE0 && in_byte_reg <= 8'hEF)
                begin
                    post.partial   = {17'd0, in_byte_reg[3:0]};
                    post.cont_left = 2'd2;
                end
                else if (in_byte_reg >= 8'hF0 && in_byte_reg <= 8'hF4)
                begin
                    post.partial   = {18'd0, in_byte_reg[2:0]};
                    post.cont_left = 2'd3;
                end
                else
                    post.failed = 1'b1;
            end
            else if (in_byte_reg[7:6] != 2'b10)
                post.failed = 1'b1;
            else if (st_reg.cont_left == 2'd3 &&
                     ((st_reg.partial == 21'd0 && in_byte_reg < 8'h90) ||
                      (st_reg.partial == 21'd4 && in_byte_reg > 8'h8F)))
                post.failed = 1'b1;
            else if (st_reg.cont_left == 2'd2 && st_reg.partial == 21'd0 &&
                     in_byte_reg < 8'hA0)
                post.failed = 1'b1;
            else
            begin
                post.partial   = shifted;
                post.cont_left = st_reg.cont_left - 2'd1;
                if (st_reg.cont_left == 2'd1)
                begin
                    post.partial = '0;
                    if (shifted > CpMax)
                        post.failed = 1'b1;
                    else
                        char_valid = 1'b1;
                end
            end
        end
        if (char_valid)
        begin
            post.esc_pending = esc_after;
            post.hex_left    = hex_after;
            post.seen_first  = 1'b1;
            post.prev_dot    = (char_cp == {13'd0, ChDot});
            if (!judge_ok)
                post.failed = 1'b1;
        end

        if (post.failed)
            verdict_next = VERDICT_INVALID;
        else if (!post.seen_first && post.cont_left == 2'd0)
            verdict_next = VERDICT_EMPTY;
        else if (post.cont_left != 2'd0 || post.esc_pending ||
                 post.hex_left != 2'd0 || post.prev_dot)
            verdict_next = VERDICT_INVALID;
        else
            verdict_next = VERDICT_VALID;

        st_next = in_last_reg ? '0 : post;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            kind_reg      <= KIND_VARIABLE;
            st_reg        <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                kind_reg <= name_kind_t'(cfg_data);
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                st_reg <= st_next;
            if (advance && in_last_reg)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg    <= s_tdata;
            in_present_reg <= s_tuser[0];
            in_last_reg    <= s_tlast;
        end
        if (advance && in_last_reg)
            out_verdict_reg <= verdict_next;
    end

    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1:0] != 2'd3))
        else $error("verdict code out of range");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_last_reg) |=> (st_reg == '0))
        else $error("name state not cleared after verdict");

    a_hex_count: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.hex_left != 2'd3)
        else $error("hex digit count out of range");

    a_esc_hex_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(st_reg.esc_pending && st_reg.hex_left != 2'd0))
        else $error("escape and percent pending together");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready && in_valid_reg && in_last_reg) |-> !advance)
        else $error("verdict overwritten while stalled");

endmodule
